/* rtl/cbp_pkg.sv */
`timescale 1ns / 1ps
// package for the command byte parser: parser phase type, command characters,
// result record and the hex digit decode; used by the top level and the bench
package cbp_pkg;

	typedef enum logic [2:0] {
		PH_IDLE        = 3'd0,
		PH_AUTO        = 3'd1,
		PH_MODE        = 3'd2,
		PH_RUMBLE_FLAG = 3'd3,
		PH_RUMBLE_HI   = 3'd4,
		PH_RUMBLE_LO   = 3'd5
	} phase_t;

	// input item kinds
	localparam logic FUNC_BYTE = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	// characters; command letters are compared after forcing lower case
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_ONE     = 8'h31;
	localparam logic [7:0] CH_TWO     = 8'h32;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_UP_A    = 8'h41;
	localparam logic [7:0] CH_UP_F    = 8'h46;
	localparam logic [7:0] CH_LO_A    = 8'h61;
	localparam logic [7:0] CH_LO_F    = 8'h66;
	localparam logic [7:0] CH_LO_M    = 8'h6D;
	localparam logic [7:0] CH_LO_P    = 8'h70;
	localparam logic [7:0] CH_LO_R    = 8'h72;
	localparam logic [7:0] CH_LO_V    = 8'h76;
	localparam logic [7:0] CASE_BIT   = 8'h20;

	typedef struct packed {
		logic       print_now;
		logic       reset_now;
		logic       auto_poll;
		logic       analog_mode;
		logic       pressure_mode;
		logic       rumble_small;
		logic [7:0] rumble_large;
		logic       parser_idle;
	} result_t;

	// ascii hex digit to nibble, anything else reads as zero
	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [7:0] d;
		begin
			d = 8'd0;
			if (c inside {[CH_ZERO:CH_NINE]}) begin
				d = c - CH_ZERO;
			end else if (c inside {[CH_UP_A:CH_UP_F]}) begin
				d = c - CH_UP_A + 8'd10;
			end else if (c inside {[CH_LO_A:CH_LO_F]}) begin
				d = c - CH_LO_A + 8'd10;
			end
			hex_value = d[3:0];
		end
	endfunction

endpackage

/* rtl/cbp_in_if.sv */
`timescale 1ns / 1ps
// input channel of the command byte parser: valid/ready plus one byte or tick
// depends on nothing
interface cbp_in_if;
	logic       valid;
	logic       ready;
	logic       func;
	logic [7:0] cmd_byte;

	modport source (output valid, output func, output cmd_byte, input ready);
	modport sink   (input valid, input func, input cmd_byte, output ready);
endinterface

/* rtl/cbp_out_if.sv */
`timescale 1ns / 1ps
// output channel of the command byte parser: valid/ready plus one status record
// depends on nothing
interface cbp_out_if;
	logic       valid;
	logic       ready;
	logic       print_now;
	logic       reset_now;
	logic       auto_poll;
	logic       analog_mode;
	logic       pressure_mode;
	logic       rumble_small;
	logic [7:0] rumble_large;
	logic       parser_idle;

	modport source (output valid, output print_now, output reset_now, output auto_poll,
		output analog_mode, output pressure_mode, output rumble_small,
		output rumble_large, output parser_idle, input ready);
	modport sink   (input valid, input print_now, input reset_now, input auto_poll,
		input analog_mode, input pressure_mode, input rumble_small,
		input rumble_large, input parser_idle, output ready);
endinterface

/* rtl/command_byte_parser.sv */
`timescale 1ns / 1ps
// command byte parser: input register, one pass of parser logic, result register
// depends on cbp_pkg, cbp_in_if and cbp_out_if
//
// an accepted item waits in the input register until its result enters the result register
// throughput: one item per cycle unless the output stalls; the input register
//   still takes one item while a result waits, after which a stalled output blocks input
// reset: arst_n clears the parser state and both valid flags at once (asynchronous);
//   modes come up analog on, pressure off, auto-poll off, rumble off
module command_byte_parser (
	input  logic             clk,
	input  logic             arst_n,
	cbp_in_if.sink           in_ch,
	cbp_out_if.source        out_ch
);

	// input register stage
	logic       valid_s1;
	logic       func_s1;
	logic [7:0] byte_s1;

	// result register
	logic             out_valid_q;
	cbp_pkg::result_t res_q;
	cbp_pkg::result_t res_d;

	// parser state
	cbp_pkg::phase_t phase_q, phase_d;
	logic       auto_q, auto_d;
	logic       analog_q, analog_d;
	logic       pressure_q, pressure_d;
	logic       stg_small_q, stg_small_d;
	logic [7:0] stg_large_q, stg_large_d;
	logic       mot_small_q, mot_small_d;
	logic [7:0] mot_large_q, mot_large_d;
	logic       print_pend_q, print_pend_d;
	logic       reset_pend_q, reset_pend_d;

	logic       advance;
	logic [7:0] lower_c;
	logic       pr, rs;

	// the held item moves into the result register when that slot is free or draining
	assign advance     = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			func_s1 <= in_ch.func;
			byte_s1 <= in_ch.cmd_byte;
		end
	end

	// letters match in either case
	assign lower_c = byte_s1 | cbp_pkg::CASE_BIT;

	// next state and result for the held item
	always_comb begin
		phase_d      = phase_q;
		auto_d       = auto_q;
		analog_d     = analog_q;
		pressure_d   = pressure_q;
		stg_small_d  = stg_small_q;
		stg_large_d  = stg_large_q;
		mot_small_d  = mot_small_q;
		mot_large_d  = mot_large_q;
		print_pend_d = print_pend_q;
		reset_pend_d = reset_pend_q;
		pr           = 1'b0;
		rs           = 1'b0;

		if (func_s1 == cbp_pkg::FUNC_TICK) begin
			// end of poll period: a pending reset wins over printing
			if (reset_pend_q) begin
				auto_d      = 1'b0;
				mot_small_d = 1'b0;
				mot_large_d = 8'd0;
				rs          = 1'b1;
			end else if (print_pend_q || auto_q) begin
				pr = 1'b1;
			end
			print_pend_d = 1'b0;
			reset_pend_d = 1'b0;
		end else begin
			case (phase_q)
				cbp_pkg::PH_IDLE: begin
					case (lower_c)
						cbp_pkg::CH_LO_A: begin
							phase_d = cbp_pkg::PH_AUTO;
							auto_d  = 1'b0;
						end
						cbp_pkg::CH_LO_M: phase_d = cbp_pkg::PH_MODE;
						cbp_pkg::CH_LO_P: print_pend_d = 1'b1;
						cbp_pkg::CH_LO_R: reset_pend_d = 1'b1;
						cbp_pkg::CH_LO_V: begin
							phase_d     = cbp_pkg::PH_RUMBLE_FLAG;
							stg_small_d = 1'b0;
							stg_large_d = 8'd0;
						end
						default: ;  // unknown bytes are dropped
					endcase
				end
				cbp_pkg::PH_AUTO: begin
					auto_d  = (byte_s1 == cbp_pkg::CH_ONE);
					phase_d = cbp_pkg::PH_IDLE;
				end
				cbp_pkg::PH_MODE: begin
					// any mode byte restarts the link; unknown codes fall back to digital
					reset_pend_d = 1'b1;
					analog_d     = (byte_s1 == cbp_pkg::CH_ONE) || (byte_s1 == cbp_pkg::CH_TWO);
					pressure_d   = (byte_s1 == cbp_pkg::CH_TWO);
					phase_d      = cbp_pkg::PH_IDLE;
				end
				cbp_pkg::PH_RUMBLE_FLAG: begin
					if (byte_s1 == cbp_pkg::CH_NEWLINE) begin
						phase_d = cbp_pkg::PH_IDLE;
					end else begin
						stg_small_d = (byte_s1 == cbp_pkg::CH_ONE);
						phase_d     = cbp_pkg::PH_RUMBLE_HI;
					end
				end
				cbp_pkg::PH_RUMBLE_HI: begin
					if (byte_s1 == cbp_pkg::CH_NEWLINE) begin
						phase_d = cbp_pkg::PH_IDLE;
					end else begin
						stg_large_d = stg_large_q | {cbp_pkg::hex_value(byte_s1), 4'd0};
						phase_d     = cbp_pkg::PH_RUMBLE_LO;
					end
				end
				cbp_pkg::PH_RUMBLE_LO: begin
					// last digit commits both motor values unless aborted by newline
					if (byte_s1 != cbp_pkg::CH_NEWLINE) begin
						stg_large_d = stg_large_q | {4'd0, cbp_pkg::hex_value(byte_s1)};
						mot_small_d = stg_small_q;
						mot_large_d = stg_large_q | {4'd0, cbp_pkg::hex_value(byte_s1)};
					end
					phase_d = cbp_pkg::PH_IDLE;
				end
				default: phase_d = cbp_pkg::PH_IDLE;  // unused codes only go back to idle
			endcase
		end

		res_d.print_now     = pr;
		res_d.reset_now     = rs;
		res_d.auto_poll     = auto_d;
		res_d.analog_mode   = analog_d;
		res_d.pressure_mode = pressure_d;
		res_d.rumble_small  = mot_small_d;
		res_d.rumble_large  = mot_large_d;
		res_d.parser_idle   = (phase_d == cbp_pkg::PH_IDLE);
	end

	// parser state register, updated once per item as it leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= cbp_pkg::PH_IDLE;
			auto_q       <= 1'b0;
			analog_q     <= 1'b1;
			pressure_q   <= 1'b0;
			stg_small_q  <= 1'b0;
			stg_large_q  <= 8'd0;
			mot_small_q  <= 1'b0;
			mot_large_q  <= 8'd0;
			print_pend_q <= 1'b0;
			reset_pend_q <= 1'b0;
		end else if (advance) begin
			phase_q      <= phase_d;
			auto_q       <= auto_d;
			analog_q     <= analog_d;
			pressure_q   <= pressure_d;
			stg_small_q  <= stg_small_d;
			stg_large_q  <= stg_large_d;
			mot_small_q  <= mot_small_d;
			mot_large_q  <= mot_large_d;
			print_pend_q <= print_pend_d;
			reset_pend_q <= reset_pend_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.print_now     = res_q.print_now;
	assign out_ch.reset_now     = res_q.reset_now;
	assign out_ch.auto_poll     = res_q.auto_poll;
	assign out_ch.analog_mode   = res_q.analog_mode;
	assign out_ch.pressure_mode = res_q.pressure_mode;
	assign out_ch.rumble_small  = res_q.rumble_small;
	assign out_ch.rumble_large  = res_q.rumble_large;
	assign out_ch.parser_idle   = res_q.parser_idle;

	// print and reset pulses are exclusive
	a_pulse_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(res_q.print_now && res_q.reset_now))
		else $error("print and reset pulsed together");

	// a reset pulse reports cleared auto-poll and rumble
	a_reset_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.reset_now) |->
		(!res_q.auto_poll && !res_q.rumble_small && (res_q.rumble_large == 8'd0)))
		else $error("reset pulse with live auto-poll or rumble");

	// a command byte never produces a pulse
	a_byte_no_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (func_s1 == cbp_pkg::FUNC_BYTE)) |=>
		(!res_q.print_now && !res_q.reset_now))
		else $error("pulse on a command byte");

	// reported idle flag follows the phase register
	a_idle_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (res_q.parser_idle == (phase_q == cbp_pkg::PH_IDLE)))
		else $error("parser_idle out of step with phase");

endmodule

/* bench/status_checker.sv */
`timescale 1ns / 1ps
// status checker for the command byte parser: predicts one status record per
// accepted input transfer and compares it with each output transfer
// depends on cbp_pkg, cbp_in_if and cbp_out_if
module status_checker (
	input  logic clk,
	input  logic arst_n,
	cbp_in_if    in_ch,
	cbp_out_if   out_ch,
	output int   mismatches,
	output int   outstanding
);

	cbp_pkg::phase_t  phase;
	logic             autopoll_on;
	logic             analog_on;
	logic             pressure_on;
	logic             stage_small;
	logic [7:0]       stage_large;
	logic             motor_sm;
	logic [7:0]       motor_lg;
	logic             want_print;
	logic             want_reset;
	cbp_pkg::result_t status_q [$];
	cbp_pkg::result_t due;

	// digits keep their low nibble, letters a-f map through the case bit
	function automatic logic [3:0] nibble_of(input logic [7:0] c);
		logic [7:0] lc;
		lc = c | cbp_pkg::CASE_BIT;
		if (c >= cbp_pkg::CH_ZERO && c <= cbp_pkg::CH_NINE) return c[3:0];
		if (lc >= cbp_pkg::CH_LO_A && lc <= cbp_pkg::CH_LO_F) return lc[3:0] + 4'd9;
		return 4'd0;
	endfunction

	function automatic cbp_pkg::result_t parse_step(input logic kind, input logic [7:0] c);
		cbp_pkg::result_t r;
		r = '0;
		if (kind == cbp_pkg::FUNC_TICK) begin
			if (want_reset) begin
				autopoll_on = 1'b0;
				motor_sm    = 1'b0;
				motor_lg    = 8'd0;
				r.reset_now = 1'b1;
			end else if (want_print || autopoll_on) begin
				r.print_now = 1'b1;
			end
			want_print = 1'b0;
			want_reset = 1'b0;
		end else begin
			case (phase)
			cbp_pkg::PH_IDLE: begin
				case (c | cbp_pkg::CASE_BIT)
				cbp_pkg::CH_LO_A: begin
					phase       = cbp_pkg::PH_AUTO;
					autopoll_on = 1'b0;
				end
				cbp_pkg::CH_LO_M: phase = cbp_pkg::PH_MODE;
				cbp_pkg::CH_LO_P: want_print = 1'b1;
				cbp_pkg::CH_LO_R: want_reset = 1'b1;
				cbp_pkg::CH_LO_V: begin
					phase       = cbp_pkg::PH_RUMBLE_FLAG;
					stage_small = 1'b0;
					stage_large = 8'd0;
				end
				default: ;
				endcase
			end
			cbp_pkg::PH_AUTO: begin
				autopoll_on = (c == cbp_pkg::CH_ONE);
				phase       = cbp_pkg::PH_IDLE;
			end
			cbp_pkg::PH_MODE: begin
				want_reset  = 1'b1;
				analog_on   = (c == cbp_pkg::CH_ONE || c == cbp_pkg::CH_TWO);
				pressure_on = (c == cbp_pkg::CH_TWO);
				phase       = cbp_pkg::PH_IDLE;
			end
			cbp_pkg::PH_RUMBLE_FLAG: begin
				if (c == cbp_pkg::CH_NEWLINE) begin
					phase = cbp_pkg::PH_IDLE;
				end else begin
					stage_small = (c == cbp_pkg::CH_ONE);
					phase       = cbp_pkg::PH_RUMBLE_HI;
				end
			end
			cbp_pkg::PH_RUMBLE_HI: begin
				if (c == cbp_pkg::CH_NEWLINE) begin
					phase = cbp_pkg::PH_IDLE;
				end else begin
					stage_large = stage_large | {nibble_of(c), 4'h0};
					phase       = cbp_pkg::PH_RUMBLE_LO;
				end
			end
			cbp_pkg::PH_RUMBLE_LO: begin
				if (c != cbp_pkg::CH_NEWLINE) begin
					stage_large = stage_large | {4'h0, nibble_of(c)};
					motor_sm    = stage_small;
					motor_lg    = stage_large;
				end
				phase = cbp_pkg::PH_IDLE;
			end
			default: phase = cbp_pkg::PH_IDLE;
			endcase
		end
		r.auto_poll     = autopoll_on;
		r.analog_mode   = analog_on;
		r.pressure_mode = pressure_on;
		r.rumble_small  = motor_sm;
		r.rumble_large  = motor_lg;
		r.parser_idle   = (phase == cbp_pkg::PH_IDLE);
		return r;
	endfunction

	task automatic compare_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			$display("%0t ns: %s expected %0h got %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase       = cbp_pkg::PH_IDLE;
			autopoll_on = 1'b0;
			analog_on   = 1'b1;
			pressure_on = 1'b0;
			stage_small = 1'b0;
			stage_large = 8'd0;
			motor_sm    = 1'b0;
			motor_lg    = 8'd0;
			want_print  = 1'b0;
			want_reset  = 1'b0;
			status_q.delete();
			mismatches  = 0;
			outstanding = 0;
		end else begin
			// oldest prediction first, so a result beside an input is never matched to it
			if (out_ch.valid && out_ch.ready) begin
				if (status_q.size() == 0) begin
					$display("%0t ns: status transfer expected none got %0h", $time,
						{out_ch.print_now, out_ch.reset_now, out_ch.auto_poll,
						out_ch.analog_mode, out_ch.pressure_mode, out_ch.rumble_small,
						out_ch.rumble_large, out_ch.parser_idle});
					mismatches++;
				end else begin
					due = status_q.pop_front();
					compare_field("print_now", due.print_now, out_ch.print_now);
					compare_field("reset_now", due.reset_now, out_ch.reset_now);
					compare_field("auto_poll", due.auto_poll, out_ch.auto_poll);
					compare_field("analog_mode", due.analog_mode, out_ch.analog_mode);
					compare_field("pressure_mode", due.pressure_mode, out_ch.pressure_mode);
					compare_field("rumble_small", due.rumble_small, out_ch.rumble_small);
					compare_field("rumble_large", due.rumble_large, out_ch.rumble_large);
					compare_field("parser_idle", due.parser_idle, out_ch.parser_idle);
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				status_q.push_back(parse_step(in_ch.func, in_ch.cmd_byte));
			end
			outstanding = status_q.size();
		end
	end

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// testbench top for the command byte parser: clock, reset, command stimulus,
// random flow control on both channels and the verdict
// depends on cbp_pkg, cbp_in_if, cbp_out_if, command_byte_parser and status_checker
module tb;

	localparam int SENDER   = 0;
	localparam int RECEIVER = 1;

	logic clk = 1'b0;
	logic arst_n;
	int   mismatches;
	int   outstanding;
	int   quiet_left [2];
	bit   squeeze;
	int   items_sent;

	cbp_in_if  in_ch ();
	cbp_out_if out_ch ();

	command_byte_parser dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// prediction and comparison live in the checker, the top only drives
	status_checker status_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ch       (in_ch),
		.out_ch      (out_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// 20 ns period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// random per-item wait, with occasional stretches of back-to-back transfers
	function automatic int draw_gap(input int side);
		if (quiet_left[side] > 0) begin
			quiet_left[side]--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0) quiet_left[side] = $urandom_range(20, 60);
		return $urandom_range(0, 14);
	endfunction

	// one input transfer; payload changes on the falling edge, ready sampled on the rising edge
	task automatic push_item(input logic kind, input logic [7:0] value);
		int gap;
		gap = squeeze ? 0 : draw_gap(SENDER);
		if (gap > 0) begin
			@(negedge clk) in_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_ch.valid    <= 1'b1;
		in_ch.func     <= kind;
		in_ch.cmd_byte <= value;
		do @(posedge clk); while (!in_ch.ready);
		items_sent++;
	endtask

	task automatic send_byte(input logic [7:0] value);
		push_item(cbp_pkg::FUNC_BYTE, value);
	endtask

	// the byte field carries junk on a tick, it must be ignored
	task automatic send_tick();
		push_item(cbp_pkg::FUNC_TICK, 8'($urandom_range(0, 255)));
	endtask

	// ticks may land in the middle of a command without disturbing the parser
	task automatic maybe_tick();
		if ($urandom_range(0, 19) == 0) send_tick();
	endtask

	function automatic logic [7:0] any_case(input logic [7:0] lower);
		return $urandom_range(0, 1) ? (lower & ~cbp_pkg::CASE_BIT) : lower;
	endfunction

	// mostly valid hex of either case, sometimes any byte (non-hex bytes decode as zero)
	function automatic logic [7:0] rumble_digit();
		string digits = "0123456789abcdefABCDEF";
		if ($urandom_range(0, 9) < 7) return digits[$urandom_range(0, 21)];
		return 8'($urandom_range(0, 255));
	endfunction

	// rumble command with random content; a newline may cut it short at any parameter
	task automatic send_rumble();
		logic [7:0] param [3];
		case ($urandom_range(0, 3))
		0, 1:    param[0] = cbp_pkg::CH_ONE;
		2:       param[0] = cbp_pkg::CH_ZERO;
		default: param[0] = 8'($urandom_range(0, 255));
		endcase
		param[1] = rumble_digit();
		param[2] = rumble_digit();
		send_byte(any_case(cbp_pkg::CH_LO_V));
		for (int i = 0; i < 3; i++) begin
			maybe_tick();
			if ($urandom_range(0, 15) == 0) begin
				send_byte(cbp_pkg::CH_NEWLINE);
				break;
			end
			send_byte(param[i]);
		end
	endtask

	// mostly well-formed commands, some ticks and some line noise
	task automatic random_command();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			send_byte(8'($urandom_range(0, 255)));
		end else if (pick < 26) begin
			send_tick();
		end else if (pick < 38) begin
			send_byte(any_case(cbp_pkg::CH_LO_A));
			maybe_tick();
			case ($urandom_range(0, 3))
			0, 1:    send_byte(cbp_pkg::CH_ONE);
			2:       send_byte(cbp_pkg::CH_ZERO);
			default: send_byte(8'($urandom_range(0, 255)));
			endcase
		end else if (pick < 48) begin
			send_byte(any_case(cbp_pkg::CH_LO_M));
			maybe_tick();
			case ($urandom_range(0, 3))
			0:       send_byte(cbp_pkg::CH_ZERO);
			1:       send_byte(cbp_pkg::CH_ONE);
			2:       send_byte(cbp_pkg::CH_TWO);
			default: send_byte(8'($urandom_range(0, 255)));
			endcase
		end else if (pick < 58) begin
			send_byte(any_case(cbp_pkg::CH_LO_P));
		end else if (pick < 64) begin
			send_byte(any_case(cbp_pkg::CH_LO_R));
		end else begin
			send_rumble();
		end
	endtask

	// receiver: random stall before each result, plus two long hold-offs that back
	// the block up until it refuses input
	initial begin : result_sink
		int gap;
		int taken;
		out_ch.ready = 1'b0;
		taken = 0;
		@(posedge arst_n);
		forever begin
			if (taken == 300 || taken == 1400) begin
				squeeze = 1'b1;
				gap = 300;
			end else begin
				gap = draw_gap(RECEIVER);
			end
			if (gap > 0) begin
				@(negedge clk) out_ch.ready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			@(negedge clk) out_ch.ready <= 1'b1;
			squeeze = 1'b0;
			do @(posedge clk); while (!out_ch.valid);
			taken++;
		end
	end

	initial begin : stimulus
		arst_n         = 1'b0;
		in_ch.valid    = 1'b0;
		in_ch.func     = cbp_pkg::FUNC_BYTE;
		in_ch.cmd_byte = 8'd0;
		quiet_left     = '{0, 0};
		items_sent     = 0;
		repeat (8) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// auto-poll on, then a tick prints on its own
		send_byte(cbp_pkg::CH_LO_A);
		send_byte(cbp_pkg::CH_ONE);
		send_tick();
		// auto-poll off, an explicit print request drives the next tick
		send_byte(cbp_pkg::CH_UP_A);
		send_byte(cbp_pkg::CH_ZERO);
		send_byte(cbp_pkg::CH_LO_P & ~cbp_pkg::CASE_BIT);
		send_tick();
		// newline as the auto parameter is just another byte
		send_byte(cbp_pkg::CH_LO_A);
		send_byte(cbp_pkg::CH_NEWLINE);
		// full rumble commit at the top of the range
		send_byte(cbp_pkg::CH_LO_V);
		send_byte(cbp_pkg::CH_ONE);
		send_byte(cbp_pkg::CH_UP_F);
		send_byte(cbp_pkg::CH_LO_F);
		// pressure mode, then newline as mode byte falls back to digital;
		// the tick then resets and clears the rumble
		send_byte(cbp_pkg::CH_LO_M);
		send_byte(cbp_pkg::CH_TWO);
		send_byte(cbp_pkg::CH_LO_M & ~cbp_pkg::CASE_BIT);
		send_byte(cbp_pkg::CH_NEWLINE);
		send_tick();
		// rumble aborted by a newline in place of the high digit
		send_byte(cbp_pkg::CH_LO_V & ~cbp_pkg::CASE_BIT);
		send_byte(cbp_pkg::CH_ZERO);
		send_byte(cbp_pkg::CH_NEWLINE);
		// non-hex digits read as zero but still commit
		send_byte(cbp_pkg::CH_LO_V);
		send_byte("x");
		send_byte("g");
		send_byte(8'hFF);
		// unknown byte while idle
		send_byte(8'h00);
		// plain reset request
		send_byte(cbp_pkg::CH_LO_R & ~cbp_pkg::CASE_BIT);
		send_tick();

		while (items_sent < 2000) random_command();
		@(negedge clk) in_ch.valid <= 1'b0;

		// drain, then keep watching to catch any stray result before the verdict
		wait (outstanding == 0);
		repeat (6) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

	// hang guard, well beyond the slowest legal run
	initial begin : watchdog
		#15_000_000;
		$display("tb failed");
		$finish;
	end

endmodule

/* sim.f */
rtl/cbp_pkg.sv
rtl/cbp_in_if.sv
rtl/cbp_out_if.sv
rtl/command_byte_parser.sv
bench/status_checker.sv
bench/tb.sv
